[design/bffe_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bffe_pkg
// Shared constants and helper functions for the seeded FNV-1a Bloom filter.
// ---------------------------------------------------------------------------
package bffe_pkg;

  // Filter geometry: the bit store is a power of two in size
  localparam int ADDR_W      = 18;
  localparam int FILTER_BITS = 1 << ADDR_W;

  // Bit store is organized as rows of ROW_W bits
  localparam int ROW_SEL_W   = 5;
  localparam int ROW_W       = 1 << ROW_SEL_W;
  localparam int ROW_AW      = ADDR_W - ROW_SEL_W;
  localparam int ROWS        = 1 << ROW_AW;

  // Hashing
  localparam int NUM_HASHES  = 7;
  localparam int IDX_W       = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam int WORD_BYTES  = 5;
  localparam int STEP_W      = $clog2(WORD_BYTES);

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] SEED_STEP = 32'h9E37_79B9;

  // Request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] hash_t;

  // Fold ASCII upper case to lower case, other bytes pass as given
  function automatic byte_t fold_byte(input byte_t b);
    byte_t r;
    r = b;
    if ((b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // One FNV-1a round: xor in a byte, multiply by the prime mod 2^32
  function automatic hash_t fnv_step(input hash_t h, input byte_t c);
    hash_t x;
    x = h ^ {24'd0, c};
    return x * FNV_PRIME;
  endfunction

endpackage

[design/bloom_filter_fnv1a_engine_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bloom_filter_fnv1a_engine_core
// Bloom filter over five-byte words with seeded 32-bit FNV-1a hashing.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_req_type and in_char_0..4 with start high; the item is
//   taken at a clock edge where start is high and busy is low. An insert
//   sets the selected filter bits and gives no result. A query gives one
//   result: out_maybe_present, shown for one cycle with out_valid high.
//   The receiver cannot stall; the result must be taken in that cycle.
// Sequence:
//   Each of the NUM_HASHES hashes runs the word's bytes through the shared
//   FNV round unit (one byte per cycle), then reads the row from the bit
//   memory and tests or writes it back. The query result appears in the
//   cycle after the last test; busy is low again in that cycle. A new
//   item is taken only after the previous one is done.
// Reset:
//   After rst_n the bit memory is cleared one row a cycle, all ROWS rows
//   (8192 for the default store); busy stays high during the clearing.
// ---------------------------------------------------------------------------
module bloom_filter_fnv1a_engine_core
  import bffe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_req_type,
  input  logic [7:0] in_char_0,
  input  logic [7:0] in_char_1,
  input  logic [7:0] in_char_2,
  input  logic [7:0] in_char_3,
  input  logic [7:0] in_char_4,
  output logic       out_valid,
  output logic       out_maybe_present
);

  // Sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;

  // Control registers
  logic [2:0]        state_r, state_nxt;
  logic [ROW_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  byte_t             chars_r [WORD_BYTES];
  logic              req_r;
  hash_t             hash_r, hash_nxt;
  hash_t             seed_r, seed_nxt;
  logic              hit_r, hit_nxt;
  logic              out_mp_r, out_mp_nxt;

  // Bit memory
  logic [ROW_W-1:0]  mem [ROWS];
  logic [ROW_W-1:0]  rd_row_r;
  logic              mem_we;
  logic              mem_re;
  logic [ROW_AW-1:0] mem_addr;
  logic [ROW_W-1:0]  mem_wdata;

  logic              accept;
  logic              sel_bit;
  hash_t             seed_inc;

  assign accept   = start && (state_r == ST_IDLE);
  assign sel_bit  = rd_row_r[hash_r[ROW_SEL_W-1:0]];
  assign seed_inc = seed_r + SEED_STEP;

  // Memory port: one read or write per cycle, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= mem[mem_addr];
    end
  end

  // Item capture with case folding
  always_ff @(posedge clk) begin
    if (accept) begin
      chars_r[0] <= fold_byte(in_char_0);
      chars_r[1] <= fold_byte(in_char_1);
      chars_r[2] <= fold_byte(in_char_2);
      chars_r[3] <= fold_byte(in_char_3);
      chars_r[4] <= fold_byte(in_char_4);
      req_r      <= in_req_type;
    end
  end

  // Sequencer next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    hash_nxt      = hash_r;
    seed_nxt      = seed_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    out_mp_nxt    = out_mp_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = hash_r[ADDR_W-1:ROW_SEL_W];
    mem_wdata     = rd_row_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ROW_AW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          hash_nxt  = FNV_BASIS;
          seed_nxt  = '0;
          step_nxt  = '0;
          idx_nxt   = '0;
          hit_nxt   = 1'b1;
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        // shared FNV round unit, one byte per cycle
        hash_nxt = fnv_step(hash_r, chars_r[step_r]);
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(WORD_BYTES - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (req_r == REQ_INSERT) begin
          mem_we    = 1'b1;
          mem_wdata = rd_row_r | (ROW_W'(1) << hash_r[ROW_SEL_W-1:0]);
        end else begin
          hit_nxt = hit_r & sel_bit;
        end
        if (idx_r == IDX_W'(NUM_HASHES - 1)) begin
          state_nxt = ST_IDLE;
          if (req_r == REQ_QUERY) begin
            out_valid_nxt = 1'b1;
            out_mp_nxt    = hit_r & sel_bit;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          seed_nxt  = seed_inc;
          hash_nxt  = FNV_BASIS ^ seed_inc;
          step_nxt  = '0;
          state_nxt = ST_HASH;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      step_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    hash_r   <= hash_nxt;
    seed_r   <= seed_nxt;
    hit_r    <= hit_nxt;
    out_mp_r <= out_mp_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_mp_r;

endmodule

[dv/bloom_filter_fnv1a_engine_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bloom_filter_fnv1a_engine_core_tb
// Self-checking bench for the seeded FNV-1a Bloom filter core. A queued
// driver sends insert and query items under random gaps. A scoreboard
// keeps its own copy of the bit store and predicts every query answer. A
// monitor checks each strobed result against the oldest prediction.
// ---------------------------------------------------------------------------
module bloom_filter_fnv1a_engine_core_tb;
  import bffe_pkg::*;

  typedef logic [4:0][7:0] word_t;   // [0] is char_0

  typedef struct {
    logic        req;
    word_t       chars;
    int unsigned gap;     // idle cycles after the previous item is taken
    bit          drain;   // hold until every pending answer is back
  } word_item_t;

  localparam int unsigned CYCLE_LIMIT = 1200000;
  localparam int unsigned TAIL_CYCLES = 64;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_req_type = 1'b0;
  logic [7:0] in_char_0 = 8'h00;
  logic [7:0] in_char_1 = 8'h00;
  logic [7:0] in_char_2 = 8'h00;
  logic [7:0] in_char_3 = 8'h00;
  logic [7:0] in_char_4 = 8'h00;
  logic       out_valid;
  logic       out_maybe_present;

  // Stimulus and scoreboard state
  word_item_t  word_q[$];
  word_item_t  cur_item;
  logic        presence_expect_q[$];
  bit          filter_model [FILTER_BITS];
  int unsigned idle_left = 0;
  int unsigned queries_sent = 0;
  int unsigned results_seen = 0;
  int unsigned inserts_done = 0;
  int unsigned hits_expected = 0;
  int unsigned misses_expected = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          dup_found;

  bloom_filter_fnv1a_engine_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_char_0         (in_char_0),
    .in_char_1         (in_char_1),
    .in_char_2         (in_char_2),
    .in_char_3         (in_char_3),
    .in_char_4         (in_char_4),
    .out_valid         (out_valid),
    .out_maybe_present (out_maybe_present)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Letters A-Z map to a-z, everything else is hashed as given
  function automatic logic [7:0] to_lower(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'h20 : b;
  endfunction

  // Filter bit picked by hash number k for a word
  function automatic logic [ADDR_W-1:0] bit_index(word_t w, int k);
    logic [31:0] h;
    logic [31:0] seed;
    seed = 32'(k) * SEED_STEP;
    h = FNV_BASIS ^ seed;
    for (int j = 0; j < WORD_BYTES; j++) begin
      h = (h ^ {24'd0, to_lower(w[j])}) * FNV_PRIME;
    end
    return h[ADDR_W-1:0];
  endfunction

  function automatic word_t mk_word(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                    logic [7:0] b3, logic [7:0] b4);
    return {b4, b3, b2, b1, b0};
  endfunction

  // Each byte is a letter in either case half the time, else an arbitrary byte
  function automatic word_t random_word();
    word_t w;
    for (int j = 0; j < WORD_BYTES; j++) begin
      if ($urandom_range(0, 1) != 0) begin
        w[j] = 8'(($urandom_range(0, 1) != 0 ? 8'h41 : 8'h61) + $urandom_range(0, 25));
      end else begin
        w[j] = 8'($urandom_range(0, 255));
      end
    end
    return w;
  endfunction

  // Same word after folding, with letters flipped to upper case at random
  function automatic word_t case_variant(word_t w);
    word_t v;
    for (int j = 0; j < WORD_BYTES; j++) begin
      v[j] = to_lower(w[j]);
      if ((v[j] >= 8'h61) && (v[j] <= 8'h7A) && ($urandom_range(0, 1) != 0)) begin
        v[j] = v[j] - 8'h20;
      end
    end
    return v;
  endfunction

  // Mostly short gaps, some medium, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 60);
    return $urandom_range(100, 300);
  endfunction

  task automatic add_item(logic req, word_t w, int unsigned gap, bit drain);
    word_q.push_back('{req, w, gap, drain});
  endtask

  // Apply a taken item to the model store; queries queue their answer
  task automatic filter_apply(word_item_t it);
    logic              hit;
    logic [ADDR_W-1:0] idx;
    hit = 1'b1;
    for (int k = 0; k < NUM_HASHES; k++) begin
      idx = bit_index(it.chars, k);
      if (it.req == REQ_INSERT) begin
        filter_model[idx] = 1'b1;
      end else if (!filter_model[idx]) begin
        hit = 1'b0;
      end
    end
    if (it.req == REQ_QUERY) begin
      presence_expect_q.push_back(hit);
      queries_sent++;
      if (hit) hits_expected++;
      else misses_expected++;
    end else begin
      inserts_done++;
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Driver: start stays up until the item is taken
  always @(posedge clk) begin : driver
    logic launch;
    launch = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        filter_apply(cur_item);
        if ((word_q.size() != 0) && (word_q[0].gap == 0) && !word_q[0].drain) begin
          launch = 1'b1;
        end else begin
          start <= 1'b0;
          idle_left = (word_q.size() != 0) ? word_q[0].gap : 0;
        end
      end else if (!start) begin
        if (idle_left != 0) begin
          idle_left--;
        end else if ((word_q.size() != 0) &&
                     (!word_q[0].drain || (queries_sent == results_seen))) begin
          launch = 1'b1;
        end
      end
      if (launch) begin
        cur_item = word_q.pop_front();
        start       <= 1'b1;
        in_req_type <= cur_item.req;
        in_char_0   <= cur_item.chars[0];
        in_char_1   <= cur_item.chars[1];
        in_char_2   <= cur_item.chars[2];
        in_char_3   <= cur_item.chars[3];
        in_char_4   <= cur_item.chars[4];
      end
    end
  end

  // Monitor: every strobed answer against the oldest prediction
  always @(posedge clk) begin : monitor
    logic want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (presence_expect_q.size() == 0) begin
        note_mismatch($sformatf("answer with no query pending: maybe_present=%0b",
                                out_maybe_present));
      end else begin
        want = presence_expect_q.pop_front();
        if (out_maybe_present !== want) begin
          note_mismatch($sformatf("maybe_present expected %0b actual %0b",
                                  want, out_maybe_present));
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bloom_filter_fnv1a_engine_core regression: fail");
      $finish;
    end
  end

  initial begin
    word_t       w;
    word_t       cand;
    word_t       known[$];
    int unsigned r;
    logic [ADDR_W-1:0] sel [NUM_HASHES];

    // Look for a word where two hashes land on the same filter bit
    dup_found = 1'b0;
    cand = '0;
    for (int unsigned n = 0; (n < 400000) && !dup_found; n++) begin
      cand = word_t'({16'h7A71, n[23:0]});
      for (int k = 0; k < NUM_HASHES; k++) sel[k] = bit_index(cand, k);
      for (int a = 0; a < NUM_HASHES; a++) begin
        for (int b = a + 1; b < NUM_HASHES; b++) begin
          if (sel[a] == sel[b]) dup_found = 1'b1;
        end
      end
    end

    // Directed: empty store, byte extremes, case folding edges, high bytes
    add_item(REQ_QUERY,  mk_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 1'b0);
    add_item(REQ_INSERT, mk_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 1'b0);
    add_item(REQ_INSERT, mk_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 3, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE), 0, 1'b0);
    add_item(REQ_INSERT, mk_word("H", "E", "L", "L", "O"), 0, 1'b0);
    add_item(REQ_QUERY,  mk_word("h", "e", "l", "l", "o"), 20, 1'b0);
    add_item(REQ_QUERY,  mk_word("H", "e", "L", "l", "O"), 0, 1'b1);
    add_item(REQ_QUERY,  mk_word("h", "e", "l", "l", "p"), 0, 1'b0);
    // 0x40 and 0x5B sit just outside the letter range and must not fold
    add_item(REQ_INSERT, mk_word(8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60), 0, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'h40, 8'h61, 8'h7A, 8'h5B, 8'h60), 0, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'h60, 8'h61, 8'h7A, 8'h5B, 8'h60), 5, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'h40, 8'h41, 8'h5A, 8'h7B, 8'h60), 0, 1'b0);
    // Bytes with the top bit set pass through unchanged
    add_item(REQ_INSERT, mk_word(8'h80, 8'hC1, 8'hDA, 8'hE1, 8'hFA), 0, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'h80, 8'hC1, 8'hDA, 8'hE1, 8'hFA), 0, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'h80, 8'hE1, 8'hDA, 8'hE1, 8'hFA), 0, 1'b0);
    add_item(REQ_QUERY,  mk_word(8'h7F, 8'h01, 8'h02, 8'h04, 8'h08), 0, 1'b0);
    if (dup_found) begin
      add_item(REQ_QUERY,  cand, 0, 1'b0);
      add_item(REQ_INSERT, cand, 0, 1'b0);
      add_item(REQ_QUERY,  cand, 0, 1'b0);
    end

    // Random: inserts, queries and re-inserts of stored words in new case, stray queries
    for (int n = 0; n < 1050; n++) begin
      r = $urandom_range(0, 99);
      if ((known.size() == 0) || (r < 40)) begin
        w = random_word();
        known.push_back(w);
        add_item(REQ_INSERT, w, 0, 1'b0);
      end else if (r < 75) begin
        add_item(REQ_QUERY, case_variant(known[$urandom_range(0, known.size() - 1)]),
                 0, 1'b0);
      end else if (r < 80) begin
        add_item(REQ_INSERT, case_variant(known[$urandom_range(0, known.size() - 1)]),
                 0, 1'b0);
      end else begin
        add_item(REQ_QUERY, random_word(), 0, 1'b0);
      end
      // back-to-back bursts at the start of each block of 120
      word_q[word_q.size() - 1].gap   = ((n % 120) < 25) ? 0 : pick_gap();
      word_q[word_q.size() - 1].drain = ((n % 150) == 149);
    end

    // Reset, then wait out the store clear via busy
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while ((word_q.size() != 0) || start) @(posedge clk);
    while (presence_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d inserts and %0d queries (%0d expected hits, %0d misses).",
             inserts_done, queries_sent, hits_expected, misses_expected);
    $display("Shared-bit word %0s; %0d mismatches.",
             dup_found ? "exercised" : "not found", mismatches);
    if ((mismatches == 0) && (presence_expect_q.size() == 0)) begin
      $display("bloom_filter_fnv1a_engine_core regression: pass");
    end else begin
      $display("bloom_filter_fnv1a_engine_core regression: fail");
    end
    $finish;
  end

endmodule
